// ===== hdl/clns_pkg.sv =====
// Shared types, constants and the helper function of the character LCD nibble sequencer.
package clns_pkg;

    localparam int NUM_ROWS = 4;
    localparam int ROW_W    = 2;
    localparam int TICK_W   = 25;
    localparam int LEN_W    = 6;
    localparam int COL_W    = 6;
    localparam int STEP_W   = 5;

    // Input kinds
    localparam logic [2:0] KIND_INIT  = 3'd0;
    localparam logic [2:0] KIND_CMD   = 3'd1;
    localparam logic [2:0] KIND_DATA  = 3'd2;
    localparam logic [2:0] KIND_PLACE = 3'd3;
    localparam logic [2:0] KIND_TEXT  = 3'd4;

    // Configuration register indexes
    localparam logic [2:0] CFG_ROW_LENGTH   = 3'd0;
    localparam logic [2:0] CFG_PULSE_TICKS  = 3'd1;
    localparam logic [2:0] CFG_GAP_TICKS    = 3'd2;
    localparam logic [2:0] CFG_SETTLE_TICKS = 3'd3;
    localparam logic [2:0] CFG_POWER_TICKS  = 3'd4;
    localparam logic [2:0] CFG_LONG_TICKS   = 3'd5;
    localparam logic [2:0] CFG_SHORT_TICKS  = 3'd6;

    // Display controller codes
    localparam logic [7:0] ROW_ADDR [4] = '{8'h80, 8'hC0, 8'h94, 8'hD4};
    localparam logic [3:0] INIT_NIB_WAKE = 4'h3;
    localparam logic [3:0] INIT_NIB_4BIT = 4'h2;
    localparam logic [7:0] CMD_CLEAR      = 8'h01;
    localparam logic [7:0] CMD_ENTRY_MODE = 8'h06;
    localparam logic [7:0] CMD_DISPLAY_ON = 8'h0C;

    // Init sequence: power-up wait, three wake nibbles and one 4-bit nibble (two steps each), three bytes
    localparam logic [STEP_W-1:0] INIT_BYTE_BASE = 5'd9;
    localparam logic [STEP_W-1:0] INIT_LAST_STEP = 5'd20;
    localparam logic [STEP_W-1:0] BYTE_LAST_STEP = 5'd3;
    localparam logic [STEP_W-1:0] PAIR_LAST_STEP = 5'd7;

    localparam logic [1:0] QUEUE_DEPTH = 2'd2;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] value;
        logic [7:0] row;
        logic [5:0] col;
    } in_item_t;

    typedef struct packed {
        logic [3:0]        nibble;
        logic              reg_select;
        logic              enable;
        logic [TICK_W-1:0] hold_ticks;
        logic              last;
    } out_item_t;

    typedef struct packed {
        logic [LEN_W-1:0]  row_length;
        logic [TICK_W-1:0] pulse_ticks;
        logic [TICK_W-1:0] gap_ticks;
        logic [TICK_W-1:0] settle_ticks;
        logic [TICK_W-1:0] power_ticks;
        logic [TICK_W-1:0] long_ticks;
        logic [TICK_W-1:0] short_ticks;
    } cfg_t;

    typedef enum logic {
        JOB_INIT,
        JOB_BYTE
    } job_op_t;

    // One queued job: the init sequence, or one byte optionally followed by a command byte
    typedef struct packed {
        job_op_t    op;
        logic [7:0] byte0;
        logic       rs0;
        logic       has2;
        logic [7:0] byte1;
    } job_t;

    // One of the four pin steps of a byte: sub[1] picks the low nibble, sub[0] the wait step
    function automatic out_item_t byte_step(logic [7:0] b, logic rs, logic [1:0] sub, cfg_t cfg);
        out_item_t o;
        o.nibble     = sub[1] ? b[3:0] : b[7:4];
        o.reg_select = rs;
        o.enable     = ~sub[0];
        o.hold_ticks = sub[0] ? (sub[1] ? cfg.settle_ticks : cfg.gap_ticks) : cfg.pulse_ticks;
        o.last       = 1'b0;
        return o;
    endfunction

endpackage

// ===== hdl/clns_queue.sv =====
// Two-entry job queue between the classifier and the pin step sequencer.
module clns_queue (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  clns_pkg::job_t push_job,
    input  logic         pop,
    output logic         full,
    output logic         head_valid,
    output clns_pkg::job_t head
);
    import clns_pkg::*;

    job_t       mem_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign full       = (count_reg == QUEUE_DEPTH);
    assign head_valid = (count_reg != 2'd0);
    assign head       = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

// ===== hdl/clns_front.sv =====
// Input classifier: tracks the cursor and turns each accepted transaction of kinds 0 to 4 into an init or byte job.
module clns_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  clns_pkg::in_item_t item,
    input  logic [5:0]         row_length,
    output logic               push,
    output clns_pkg::job_t     job
);
    import clns_pkg::*;

    logic [ROW_W-1:0] cursor_row_reg;
    logic [ROW_W-1:0] cursor_row_next;
    logic [COL_W-1:0] cursor_col_reg;
    logic [COL_W-1:0] cursor_col_next;

    logic [ROW_W-1:0] place_row;
    logic [ROW_W-1:0] wrap_row;
    logic [COL_W:0]   col_inc;
    logic             wrap;

    always_comb
    begin
        place_row = (item.row >= 8'(NUM_ROWS)) ? '0 : item.row[ROW_W-1:0];
        wrap_row  = (cursor_row_reg == ROW_W'(NUM_ROWS - 1)) ? '0 : cursor_row_reg + 1'b1;
        col_inc   = {1'b0, cursor_col_reg} + 1'b1;
        wrap      = (col_inc >= {1'b0, row_length});
    end

    always_comb
    begin
        push            = 1'b0;
        job.op          = JOB_BYTE;
        job.byte0       = item.value;
        job.rs0         = 1'b0;
        job.has2        = 1'b0;
        job.byte1       = ROW_ADDR[wrap_row];
        cursor_row_next = cursor_row_reg;
        cursor_col_next = cursor_col_reg;
        unique case (item.kind)
            KIND_INIT:
            begin
                push            = accept;
                job.op          = JOB_INIT;
                cursor_row_next = '0;
                cursor_col_next = '0;
            end
            KIND_CMD:
            begin
                push = accept;
            end
            KIND_DATA:
            begin
                push    = accept;
                job.rs0 = 1'b1;
            end
            KIND_PLACE:
            begin
                push            = accept;
                job.byte0       = ROW_ADDR[place_row] + {2'b00, item.col};
                cursor_row_next = place_row;
                cursor_col_next = item.col;
            end
            KIND_TEXT:
            begin
                push     = accept;
                job.rs0  = 1'b1;
                job.has2 = wrap;
                if (wrap)
                begin
                    cursor_row_next = wrap_row;
                    cursor_col_next = '0;
                end
                else
                begin
                    cursor_col_next = col_inc[COL_W-1:0];
                end
            end
            default:
            begin
                push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_row_reg <= '0;
            cursor_col_reg <= '0;
        end
        else if (accept)
        begin
            cursor_row_reg <= cursor_row_next;
            cursor_col_reg <= cursor_col_next;
        end
    end

endmodule

// ===== hdl/clns_back.sv =====
// Pin step sequencer: walks the queue head job one pin step per cycle into the output register unless stalled.
module clns_back (
    input  logic                clk,
    input  logic                rst_n,
    input  clns_pkg::cfg_t      cfg,
    input  logic                head_valid,
    input  clns_pkg::job_t      head,
    output logic                pop,
    input  logic                out_stall,
    output logic                out_valid,
    output clns_pkg::out_item_t out_item
);
    import clns_pkg::*;

    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    out_item_t         out_item_reg;

    logic              advance;
    out_item_t         cur;
    logic [2:0]        wake_idx;
    logic [1:0]        wake_nib;
    logic [3:0]        init_byte_idx;
    logic [7:0]        init_byte;

    assign advance   = head_valid && (!out_valid_reg || !out_stall);
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    always_comb
    begin
        wake_idx      = 3'(step_reg - 1'b1);
        wake_nib      = wake_idx[2:1];
        init_byte_idx = 4'(step_reg - INIT_BYTE_BASE);
        unique case (init_byte_idx[3:2])
            2'd0:    init_byte = CMD_CLEAR;
            2'd1:    init_byte = CMD_ENTRY_MODE;
            default: init_byte = CMD_DISPLAY_ON;
        endcase

        unique case (head.op)
            JOB_INIT:
            begin
                if (step_reg == '0)
                begin
                    cur.nibble     = '0;
                    cur.reg_select = 1'b0;
                    cur.enable     = 1'b0;
                    cur.hold_ticks = cfg.power_ticks;
                    cur.last       = 1'b0;
                end
                else if (step_reg < INIT_BYTE_BASE)
                begin
                    cur.nibble     = (wake_nib == 2'd3) ? INIT_NIB_4BIT : INIT_NIB_WAKE;
                    cur.reg_select = 1'b0;
                    cur.enable     = ~wake_idx[0];
                    if (!wake_idx[0])
                        cur.hold_ticks = cfg.pulse_ticks;
                    else
                        cur.hold_ticks = wake_nib[1] ? cfg.short_ticks : cfg.long_ticks;
                    cur.last       = 1'b0;
                end
                else
                begin
                    cur = byte_step(init_byte, 1'b0, init_byte_idx[1:0], cfg);
                end
                cur.last = (step_reg == INIT_LAST_STEP);
            end
            JOB_BYTE:
            begin
                if (step_reg[2])
                    cur = byte_step(head.byte1, 1'b0, step_reg[1:0], cfg);
                else
                    cur = byte_step(head.byte0, head.rs0, step_reg[1:0], cfg);
                cur.last = head.has2 ? (step_reg == PAIR_LAST_STEP)
                                     : (step_reg == BYTE_LAST_STEP);
            end
            default:
            begin
                cur = '0;
            end
        endcase
    end

    always_comb
    begin
        pop            = advance && cur.last;
        step_next      = step_reg;
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            step_next      = cur.last ? '0 : step_reg + 1'b1;
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_item_reg <= cur;
        end
    end

endmodule

// ===== hdl/char_lcd_nibble_sequencer.sv =====
// Top level of the character LCD nibble sequencer: config registers, classifier, queue, sequencer.
//
// Input channel (in_valid / in_stall / in_item): one transaction per display request
// (init, command byte, data byte, place cursor, text character). Output channel
// (out_valid / out_stall / out_item): one transaction per pin step; the consumer holds
// the pins for hold_ticks cycles, and last marks the final step of a request.
// The job queue registers each request taken; the sequencer then loads its first pin step
// into the output register. The sequencer emits one pin step per cycle unless out_stall
// holds a valid output, and a request takes 4 pin steps (command, data, place), 4 or 8
// (text, 8 when it wraps to the next row) or 21 (init); kinds 5 to 7 are taken and dropped.
// A two-entry job queue lets requests be taken while earlier ones are still being
// sequenced; in_stall rises only when that queue is full.
// When out_stall is high while an output is valid, the output register holds its
// transaction and the sequencer waits; the queue then fills and stalls the input.
// Reset clears the cursor, the queue and the output valid, and loads the default config
// registers. Config writes (cfg_we, cfg_index, cfg_data) take effect once registered.
module char_lcd_nibble_sequencer (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  clns_pkg::in_item_t  in_item,
    output logic                out_valid,
    input  logic                out_stall,
    output clns_pkg::out_item_t out_item,
    input  logic                cfg_we,
    input  logic [2:0]          cfg_index,
    input  logic [24:0]         cfg_data
);
    import clns_pkg::*;

    cfg_t cfg_reg;
    logic accept;
    logic push;
    job_t push_job;
    logic pop;
    logic full;
    logic head_valid;
    job_t head;

    assign in_stall = full;
    assign accept   = in_valid && !full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.row_length   <= LEN_W'(16);
            cfg_reg.pulse_ticks  <= TICK_W'(1000);
            cfg_reg.gap_ticks    <= TICK_W'(5000);
            cfg_reg.settle_ticks <= TICK_W'(250000);
            cfg_reg.power_ticks  <= TICK_W'(25000000);
            cfg_reg.long_ticks   <= TICK_W'(2500000);
            cfg_reg.short_ticks  <= TICK_W'(500000);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_ROW_LENGTH:   cfg_reg.row_length   <= cfg_data[LEN_W-1:0];
                CFG_PULSE_TICKS:  cfg_reg.pulse_ticks  <= cfg_data;
                CFG_GAP_TICKS:    cfg_reg.gap_ticks    <= cfg_data;
                CFG_SETTLE_TICKS: cfg_reg.settle_ticks <= cfg_data;
                CFG_POWER_TICKS:  cfg_reg.power_ticks  <= cfg_data;
                CFG_LONG_TICKS:   cfg_reg.long_ticks   <= cfg_data;
                CFG_SHORT_TICKS:  cfg_reg.short_ticks  <= cfg_data;
                default:          cfg_reg              <= cfg_reg;
            endcase
        end
    end

    clns_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .item       (in_item),
        .row_length (cfg_reg.row_length),
        .push       (push),
        .job        (push_job)
    );

    clns_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_job   (push_job),
        .pop        (pop),
        .full       (full),
        .head_valid (head_valid),
        .head       (head)
    );

    clns_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .out_stall  (out_stall),
        .out_valid  (out_valid),
        .out_item   (out_item)
    );

endmodule
